@@ src/audio_level_meter_autogain_core_macros.svh @@
// Assertion macros for the audio level meter core.
// Uses the aclk and aresetn ports of the module that includes it; no other dependency.
`ifndef AUDIO_LEVEL_METER_AUTOGAIN_CORE_MACROS_SVH
`define AUDIO_LEVEL_METER_AUTOGAIN_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ALM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define ALM_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/alm_pkg.sv @@
// Shared constants and types for the audio level meter core.
// No dependencies; used by alm_div and audio_level_meter_autogain_core.
package alm_pkg;

    localparam int SMP_W  = 10;   // raw sample
    localparam int MAG_W  = 10;   // magnitude after noise floor
    localparam int LVL_W  = 10;   // smoothed level
    localparam int AVG_W  = 11;   // running min / max averages
    localparam int NF_W   = 9;
    localparam int FP_W   = 8;
    localparam int OFF_W  = 9;
    localparam int CFG_W  = 9;
    localparam int CFG_AW = 2;

    localparam logic [CFG_AW-1:0] CFG_NOISE_FLOOR = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_PEAK_FALL   = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_DC_OFFSET   = 2'd2;

    localparam logic [NF_W-1:0]  NF_RST     = 9'd10;
    localparam logic [FP_W-1:0]  FP_RST     = 8'd15;
    localparam logic [OFF_W-1:0] OFF_RST    = 9'd0;
    localparam logic [LVL_W-1:0] LVL_RST    = 10'd2;
    localparam logic [AVG_W-1:0] MINAVG_RST = 11'd0;
    localparam logic [AVG_W-1:0] MAXAVG_RST = 11'd512;
    localparam int               PEAK_RST   = 6;
    localparam int               MIDPOINT   = 512;

    typedef struct packed {
        logic done;   // one-cycle pulse, quotient valid
        logic sat;    // quotient does not fit the quotient width
    } div_stat_t;

endpackage

@@ src/alm_div.sv @@
// Restoring divider, one quotient bit per cycle through a single subtractor.
// Depends on alm_pkg for the status struct.
module alm_div #(
    parameter int NW = 16,
    parameter int DW = 11,
    parameter int QB = 5
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [NW-1:0]        num,
    input  logic [DW-1:0]        den,
    output logic [QB-1:0]        quo,
    output alm_pkg::div_stat_t   stat
);

    localparam int CW    = ((NW > DW + QB) ? NW : DW + QB) + 1;
    localparam int CNT_W = $clog2(QB + 1);

    logic [NW-1:0]    rem_reg;
    logic [CW-2:0]    dsh_reg;
    logic [QB-1:0]    q_reg;
    logic             sat_reg;
    logic             run_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;

    logic [CW-1:0]    diff;
    logic             ge;

    assign diff = {1'b0, (CW-1)'(rem_reg)} - {1'b0, dsh_reg};
    assign ge   = !diff[CW-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                run_reg <= 1'b1;
                cnt_reg <= CNT_W'(QB);
            end else if (run_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= num;
            dsh_reg <= (CW-1)'(den) << QB;
            q_reg   <= '0;
            sat_reg <= 1'b0;
        end else if (run_reg) begin
            dsh_reg <= dsh_reg >> 1;
            if (cnt_reg == CNT_W'(QB)) begin
                // top step only checks for overflow of the quotient
                sat_reg <= ge;
            end else begin
                q_reg <= {q_reg[QB-2:0], ge};
                if (ge) begin
                    rem_reg <= diff[NW-1:0];
                end
            end
        end
    end

    assign quo       = q_reg;
    assign stat.done = done_reg;
    assign stat.sat  = sat_reg;

endmodule

@@ src/audio_level_meter_autogain_core.sv @@
// Audio level meter: noise-gated magnitude, 7/8 smoother, auto-ranged bar and peak dot.
// Each sample runs through the filter, prepare, divide, peak, window scan, average and output
// steps; the divide step is skipped when the divisor is zero or the signs differ (no divide).
// The next input is taken in the cycle after the result loads, so a new sample is not taken
// before the last one is through; the divider quotient width is HW = clog2(COLUMN_HEIGHT + 3),
// the window scan reads every entry; reset (aresetn low, sync) restores state, config, valids.
`include "audio_level_meter_autogain_core_macros.svh"

module audio_level_meter_autogain_core #(
    parameter int WINDOW_LENGTH = 6,
    parameter int COLUMN_HEIGHT = 16,
    localparam int TOP      = COLUMN_HEIGHT + 2,
    localparam int HW       = $clog2(TOP + 1),
    localparam int OUT_BITS = 2 * HW + 1 + alm_pkg::LVL_W,
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8,
    localparam int IN_W     = ((alm_pkg::SMP_W + 7) / 8) * 8
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [IN_W-1:0]             s_tdata,   // sample
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [OUT_W-1:0]            m_tdata,   // bar_height, peak_level, peak_shown,
                                                   // smoothed_level
    input  logic                        cfg_we,
    input  logic [alm_pkg::CFG_AW-1:0]  cfg_addr,
    input  logic [alm_pkg::CFG_W-1:0]   cfg_wdata
);

    localparam int AW    = $clog2(WINDOW_LENGTH);
    localparam int SW    = $clog2(WINDOW_LENGTH + 1);
    localparam int NW    = $clog2(TOP * ((1 << alm_pkg::AVG_W) - 1) + 1);
    localparam int DIF_W = alm_pkg::SMP_W + 2;
    localparam int AV_W  = alm_pkg::AVG_W;
    localparam int LV_W  = alm_pkg::LVL_W;
    localparam int MG_W  = alm_pkg::MAG_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_FILT = 3'd1;
    localparam logic [2:0] S_PREP = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_PEAK = 3'd4;
    localparam logic [2:0] S_SCAN = 3'd5;
    localparam logic [2:0] S_AVG  = 3'd6;
    localparam logic [2:0] S_OUT  = 3'd7;

    logic [2:0]                 state_reg, state_next;

    logic [alm_pkg::NF_W-1:0]   nf_reg;
    logic [alm_pkg::FP_W-1:0]   fp_reg;
    logic [alm_pkg::OFF_W-1:0]  off_reg;

    logic [MG_W-1:0]            mag_reg;
    logic [LV_W-1:0]            lf_reg;
    logic [AV_W-1:0]            min_avg_reg, max_avg_reg;
    logic [AW-1:0]              widx_reg;
    logic [WINDOW_LENGTH-1:0]   win_vld_reg;
    logic [MG_W-1:0]            win_mem [WINDOW_LENGTH];
    logic [MG_W-1:0]            rd_data_reg;
    logic                       rd_vld_reg;
    logic [SW-1:0]              scan_cnt_reg;
    logic [MG_W-1:0]            lo_reg, hi_reg;
    logic [alm_pkg::FP_W-1:0]   fall_cnt_reg;
    logic [HW-1:0]              peak_hold_reg;
    logic [HW-1:0]              height_reg;
    logic [HW-1:0]              res_peak_reg;

    logic                       m_tvalid_reg;
    logic [HW-1:0]              m_bar_reg, m_peak_reg;
    logic                       m_shown_reg;
    logic [LV_W-1:0]            m_lvl_reg;

    // magnitude path
    logic [DIF_W-1:0]           diff_c, diff_neg_c;
    logic [MG_W-1:0]            mag_abs_c, mag_cut_c;
    // smoother
    logic [LV_W+2:0]            lf7_c, lf_sum_c;
    // divide operands
    logic [AV_W:0]              dn_c, dn_neg_c, den_c, den_neg_c;
    logic [AV_W-1:0]            dn_abs_c, den_abs_c;
    logic [NW-1:0]              num_abs_c;
    logic                       div_start;
    logic [HW-1:0]              quo;
    alm_pkg::div_stat_t         div_stat;
    logic [HW-1:0]              quo_clip_c;
    // peak
    logic [HW-1:0]              pk_rise_c;
    logic [alm_pkg::FP_W-1:0]   fc_inc_c;
    logic                       drop_c;
    // scan and averages
    logic [MG_W-1:0]            entry_c;
    logic [AV_W-1:0]            hi_adj_c;
    logic [AV_W+5:0]            min63_c, max63_c;
    logic                       out_load;

    assign s_tready = (state_reg == S_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nf_reg  <= alm_pkg::NF_RST;
            fp_reg  <= alm_pkg::FP_RST;
            off_reg <= alm_pkg::OFF_RST;
        end else if (cfg_we) begin
            case (cfg_addr)
                alm_pkg::CFG_NOISE_FLOOR: nf_reg  <= cfg_wdata[alm_pkg::NF_W-1:0];
                alm_pkg::CFG_PEAK_FALL:   fp_reg  <= cfg_wdata[alm_pkg::FP_W-1:0];
                alm_pkg::CFG_DC_OFFSET:   off_reg <= cfg_wdata[alm_pkg::OFF_W-1:0];
                default: ;
            endcase
        end
    end

    // center on midpoint plus offset, take magnitude, remove noise floor
    always_comb begin
        diff_c = {2'b00, s_tdata[alm_pkg::SMP_W-1:0]} - DIF_W'(alm_pkg::MIDPOINT)
                 - {{(DIF_W-alm_pkg::OFF_W){off_reg[alm_pkg::OFF_W-1]}}, off_reg};
        diff_neg_c = -diff_c;
        mag_abs_c  = diff_c[DIF_W-1] ? diff_neg_c[MG_W-1:0] : diff_c[MG_W-1:0];
        mag_cut_c  = (mag_abs_c > MG_W'(nf_reg)) ? mag_abs_c - MG_W'(nf_reg) : '0;
    end

    assign lf7_c    = {lf_reg, 3'b000} - {3'b000, lf_reg};
    assign lf_sum_c = lf7_c + {3'b000, mag_reg};

    always_comb begin
        dn_c      = {{(AV_W+1-LV_W){1'b0}}, lf_reg} - {1'b0, min_avg_reg};
        den_c     = {1'b0, max_avg_reg} - {1'b0, min_avg_reg};
        dn_neg_c  = -dn_c;
        den_neg_c = -den_c;
        dn_abs_c  = dn_c[AV_W] ? dn_neg_c[AV_W-1:0] : dn_c[AV_W-1:0];
        den_abs_c = den_c[AV_W] ? den_neg_c[AV_W-1:0] : den_c[AV_W-1:0];
        num_abs_c = NW'(dn_abs_c * TOP);
    end

    // signs agree and divisor nonzero: quotient is non-negative, divide magnitudes
    assign div_start = (state_reg == S_PREP) && (den_c != '0) && !(dn_c[AV_W] ^ den_c[AV_W]);

    alm_div #(
        .NW (NW),
        .DW (AV_W),
        .QB (HW)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (num_abs_c),
        .den     (den_abs_c),
        .quo     (quo),
        .stat    (div_stat)
    );

    assign quo_clip_c = (div_stat.sat || quo > HW'(TOP)) ? HW'(TOP) : quo;

    assign pk_rise_c = (height_reg > peak_hold_reg) ? height_reg : peak_hold_reg;
    assign fc_inc_c  = fall_cnt_reg + 1'b1;
    assign drop_c    = (fc_inc_c >= fp_reg);

    assign entry_c  = rd_vld_reg ? rd_data_reg : '0;
    assign hi_adj_c = ((hi_reg - lo_reg) < MG_W'(TOP)) ? AV_W'(lo_reg) + AV_W'(TOP)
                                                        : AV_W'(hi_reg);
    assign min63_c  = {min_avg_reg, 6'b000000} - (AV_W+6)'(min_avg_reg) + (AV_W+6)'(lo_reg);
    assign max63_c  = {max_avg_reg, 6'b000000} - (AV_W+6)'(max_avg_reg) + (AV_W+6)'(hi_adj_c);

    assign out_load = (state_reg == S_OUT) && (!m_tvalid_reg || m_tready);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (s_tvalid) state_next = S_FILT;
            S_FILT: state_next = S_PREP;
            S_PREP: state_next = div_start ? S_DIV : S_PEAK;
            S_DIV:  if (div_stat.done) state_next = S_PEAK;
            S_PEAK: state_next = S_SCAN;
            S_SCAN: if (scan_cnt_reg == SW'(WINDOW_LENGTH)) state_next = S_AVG;
            S_AVG:  state_next = S_OUT;
            S_OUT:  if (out_load) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            lf_reg        <= alm_pkg::LVL_RST;
            min_avg_reg   <= alm_pkg::MINAVG_RST;
            max_avg_reg   <= alm_pkg::MAXAVG_RST;
            widx_reg      <= '0;
            win_vld_reg   <= '0;
            fall_cnt_reg  <= '0;
            peak_hold_reg <= HW'(alm_pkg::PEAK_RST);
            scan_cnt_reg  <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            case (state_reg)
                S_FILT: begin
                    lf_reg                <= lf_sum_c[LV_W+2:3];
                    win_vld_reg[widx_reg] <= 1'b1;
                    widx_reg <= (widx_reg == AW'(WINDOW_LENGTH - 1)) ? '0 : widx_reg + 1'b1;
                end
                S_PEAK: begin
                    fall_cnt_reg  <= drop_c ? '0 : fc_inc_c;
                    peak_hold_reg <= (drop_c && pk_rise_c != '0) ? pk_rise_c - 1'b1
                                                                 : pk_rise_c;
                    scan_cnt_reg  <= '0;
                end
                S_SCAN: scan_cnt_reg <= scan_cnt_reg + 1'b1;
                S_AVG: begin
                    min_avg_reg <= min63_c[AV_W+5:6];
                    max_avg_reg <= max63_c[AV_W+5:6];
                end
                default: ;
            endcase
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // payload and window memory, no reset needed
    always_ff @(posedge aclk) begin
        if (state_reg == S_IDLE) begin
            mag_reg <= mag_cut_c;
        end
        if (state_reg == S_FILT) begin
            win_mem[widx_reg] <= mag_reg;
        end
        if (state_reg == S_SCAN && scan_cnt_reg < SW'(WINDOW_LENGTH)) begin
            rd_data_reg <= win_mem[scan_cnt_reg[AW-1:0]];
            rd_vld_reg  <= win_vld_reg[scan_cnt_reg[AW-1:0]];
        end
        if (state_reg == S_SCAN) begin
            // read data is registered and arrives in the cycle after its address
            if (scan_cnt_reg == SW'(1)) begin
                lo_reg <= entry_c;
                hi_reg <= entry_c;
            end else if (scan_cnt_reg != '0) begin
                if (entry_c < lo_reg) lo_reg <= entry_c;
                if (entry_c > hi_reg) hi_reg <= entry_c;
            end
        end
        if (state_reg == S_PREP) begin
            // zero divisor saturates; opposite signs clip to zero
            if (den_c == '0) begin
                height_reg <= HW'(TOP);
            end else if (!div_start) begin
                height_reg <= '0;
            end
        end
        if (state_reg == S_DIV && div_stat.done) begin
            height_reg <= quo_clip_c;
        end
        if (state_reg == S_PEAK) begin
            res_peak_reg <= pk_rise_c;
        end
        if (out_load) begin
            m_bar_reg   <= height_reg;
            m_peak_reg  <= res_peak_reg;
            m_shown_reg <= (res_peak_reg != '0) && (res_peak_reg <= HW'(COLUMN_HEIGHT - 1));
            m_lvl_reg   <= lf_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OUT_W'({m_lvl_reg, m_shown_reg, m_peak_reg, m_bar_reg});

    `ALM_ASSERT_IMP(a_div_done_in_div, div_stat.done, state_reg == S_DIV, "stray divider done")
    `ALM_ASSERT_NXT(a_accept_starts, s_tvalid && s_tready, state_reg == S_FILT, "no filter step")
    `ALM_ASSERT_IMP(a_bar_in_range, m_tvalid, m_tdata[HW-1:0] <= HW'(TOP), "bar above top")
    `ALM_ASSERT_IMP(a_peak_in_range, 1'b1, peak_hold_reg <= HW'(TOP), "peak above top")

endmodule
